// File: hw/rtl/lfoam_pkg.sv
// Shared constants, types and waveform tables of the LFO amplitude modulator.
package lfoam_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 24;

  localparam int TBL_N      = 1 << TABLE_ADDR_BITS;
  localparam int STEP_BITS  = 24;
  localparam int DEPTH_BITS = 16;
  localparam int SHAPE_BITS = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam int MUL_BITS   = 32;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEPTH      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_SHAPE = 2'd2;

  // Wave shape codes
  localparam logic [SHAPE_BITS-1:0] SHAPE_SINE    = 2'd0;
  localparam logic [SHAPE_BITS-1:0] SHAPE_MOD     = 2'd1;
  localparam logic [SHAPE_BITS-1:0] SHAPE_TRI     = 2'd2;
  localparam logic [SHAPE_BITS-1:0] SHAPE_MOD_ALT = 2'd3;

  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 24'd44739;
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 16'd0;
  localparam logic [SHAPE_BITS-1:0] SHAPE_RESET = SHAPE_MOD;
  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL  = 16'd32768;

  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] Q28_ONE    = 64'd1 << 28;
  localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
  localparam logic [63:0] C015_Q30   = 64'd161061274;
  localparam logic [63:0] C13_Q30    = 64'd1395864371;

  typedef logic signed [15:0] tbl_t [TBL_N];

  typedef struct packed {
    logic load;   // capture sample and phase taps, advance phase
    logic look;   // table read and waveform select
    logic gain;   // gain product
    logic scale;  // sample product into output register
  } lfoam_cmd_t;

  // Unsigned quotient, restoring shift and subtract.
  function automatic logic [63:0] lfoam_udiv(input logic [63:0] num,
                                             input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem = rem - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine magnitude in Q30, Taylor series to x^15.
  function automatic logic [63:0] lfoam_sin_quarter(input logic [63:0] r);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    t = r << (30 - (TABLE_ADDR_BITS - 2));
    x = (t * PIHALF_Q30) >> 30;
    sum = $signed(x);
    term = x;
    for (int k = 1; k <= 7; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) sum = 64'sd0;
    return 64'(sum);
  endfunction

  function automatic logic signed [63:0] lfoam_sin_at(input logic [63:0] k);
    logic [63:0] qsize;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] m;
    qsize = 64'(TBL_N) >> 2;
    quad = (k >> (TABLE_ADDR_BITS - 2)) & 64'd3;
    r = k & (qsize - 64'd1);
    m = quad[0] ? lfoam_sin_quarter(qsize - r) : lfoam_sin_quarter(r);
    return quad[1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] lfoam_smul_q30(input logic signed [63:0] a,
                                                       input logic [63:0] c);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    p = (mag * c) >> 30;
    return (a < 0) ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [63:0] lfoam_exp_q28(input logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    sum = Q28_ONE;
    term = Q28_ONE;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * z) >> 28) / 64'(n);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic signed [15:0] lfoam_q15(input logic signed [63:0] v,
                                                  input logic [63:0] mag);
    logic [15:0] m;
    m = (mag > 64'd32767) ? 16'd32767 : mag[15:0];
    return (v < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic tbl_t lfoam_build_sine();
    tbl_t tbl;
    logic signed [63:0] s1;
    logic [63:0] m1;
    for (int i = 0; i < TBL_N; i++) begin
      s1 = lfoam_sin_at(64'(i));
      m1 = (s1 < 0) ? 64'(-s1) : 64'(s1);
      tbl[i] = lfoam_q15(s1, (m1 + 64'd16384) >> 15);
    end
    return tbl;
  endfunction

  // tanh(1.3 * (sin + 0.15 * sin3)), via (e-1)/(e+1) with e = exp(2|y|)
  function automatic tbl_t lfoam_build_mod();
    tbl_t tbl;
    logic signed [63:0] s1;
    logic signed [63:0] s3;
    logic signed [63:0] y;
    logic [63:0] my;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] th;
    for (int i = 0; i < TBL_N; i++) begin
      s1 = lfoam_sin_at(64'(i));
      s3 = lfoam_sin_at(64'((3 * i) & (TBL_N - 1)));
      y = lfoam_smul_q30(s1 + lfoam_smul_q30(s3, C015_Q30), C13_Q30);
      my = (y < 0) ? 64'(-y) : 64'(y);
      e = lfoam_exp_q28(my >> 1);
      den = e + Q28_ONE;
      th = lfoam_udiv(((e - Q28_ONE) << 15) + (den >> 1), den);
      tbl[i] = lfoam_q15(y, th);
    end
    return tbl;
  endfunction

  localparam tbl_t SINE_TBL = lfoam_build_sine();
  localparam tbl_t MOD_TBL  = lfoam_build_mod();

endpackage

// File: hw/rtl/lfo_amplitude_modulator_unit.sv
// Top level of the LFO amplitude modulator (tremolo).
//
// Input channel: sample_in with in_valid / in_stall; a request is taken on a
// rising edge with in_valid high and in_stall low. Output channel: sample_out
// with out_valid / out_stall, same rule. Config: cfg_valid / cfg_ready with
// cfg_index (0 phase_step, 1 depth, 2 wave_shape) and cfg_data; cfg_ready is
// always high, writes to index 3 are dropped. Write config only when idle.
// Each request: table read, gain product, sample product, one per state
// (LOOK, GAIN, SCALE); SCALE writes the output register, and no new request
// is taken until then. The pace is set by the one multiplier shared by the gain
// and the sample products, plus the registered table read.
// The output register decouples the sides: a new request is taken while a
// finished result waits. If the receiver stalls, the next result waits in
// the scale step and no further request is taken until the register frees.
// Reset (rst, synchronous) zeroes the LFO phase, restores the registers to
// step 44739, depth 0, modified sine, and empties the output register. The
// waveform tables are constant ROMs, so no fill pass follows reset.
module lfo_amplitude_modulator_unit
  import lfoam_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  lfoam_cmd_t cmd;

  // config writes are registered and always taken
  assign cfg_ready = 1'b1;

  lfoam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lfoam_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

endmodule

// File: hw/rtl/lfoam_ctrl.sv
// Sequencer of the LFO amplitude modulator: handshakes and datapath commands.
module lfoam_ctrl
  import lfoam_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output lfoam_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_GAIN,
    S_SCALE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.look  = (state == S_LOOK);
    cmd.gain  = (state == S_GAIN);
    cmd.scale = (state == S_SCALE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scale) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_LOOK;
        end
        S_LOOK: begin
          state <= S_GAIN;
        end
        S_GAIN: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_LOOK))
    else $error("accepted request did not start the table read");

  a_gain_then_scale: assert property (@(posedge clk) disable iff (rst)
    (state == S_GAIN) |=> (state == S_SCALE))
    else $error("gain step not followed by scale step");

  a_scale_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE && out_valid && out_stall) |=> (state == S_SCALE && out_valid))
    else $error("result overwrote a stalled result");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SCALE))
    else $error("result raised outside the scale step");

endmodule

// File: hw/rtl/lfoam_datapath.sv
// Datapath: config registers, phase accumulator, waveform tables, shared multiplier.
module lfoam_datapath
  import lfoam_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  lfoam_cmd_t                    cmd,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  logic [STEP_BITS-1:0]  phase_step;
  logic [DEPTH_BITS-1:0] depth;
  logic [SHAPE_BITS-1:0] wave_shape;
  logic [PHASE_BITS-1:0] lfo_phase;

  logic [PHASE_BITS+STEP_BITS-1:0] phase_sum;
  logic [PHASE_BITS+16:0]          phase_ext;
  logic [16:0]                     tri_u;
  logic signed [17:0]              tri_raw;
  logic signed [15:0]              tri_w;

  logic [TABLE_ADDR_BITS-1:0] idx_q;
  logic signed [15:0]         tri_q;
  logic signed [15:0]         w_q;
  logic [SAMPLE_BITS-1:0]     mag_q;
  logic                       neg_q;
  logic [MUL_BITS-1:0]        g_q;

  logic [DEPTH_BITS-1:0]   depth_sat;
  logic signed [17:0]      diff_wide;
  logic [MUL_BITS-1:0]     op_a;
  logic [MUL_BITS-1:0]     op_b;
  logic [2*MUL_BITS-1:0]   prod;
  logic [SAMPLE_BITS-1:0]  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      depth      <= DEPTH_RESET;
      wave_shape <= SHAPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step <= cfg_data[STEP_BITS-1:0];
        CFG_DEPTH:      depth      <= cfg_data[DEPTH_BITS-1:0];
        CFG_WAVE_SHAPE: wave_shape <= cfg_data[SHAPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign phase_sum = {{STEP_BITS{1'b0}}, lfo_phase} + {{PHASE_BITS{1'b0}}, phase_step};

  // triangle from the top 17 phase bits
  assign phase_ext = {lfo_phase, 17'b0};
  assign tri_u     = phase_ext[PHASE_BITS+16:PHASE_BITS];
  assign tri_raw   = tri_u[16] ? (18'sd98304 - $signed({1'b0, tri_u}))
                               : ($signed({1'b0, tri_u}) - 18'sd32768);
  assign tri_w     = (tri_raw > 18'sd32767) ? 16'sd32767 : tri_raw[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase <= '0;
    end else if (cmd.load) begin
      lfo_phase <= phase_sum[PHASE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q <= lfo_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      tri_q <= tri_w;
      neg_q <= sample_in[SAMPLE_BITS-1];
      mag_q <= sample_in[SAMPLE_BITS-1] ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      unique case (wave_shape)
        SHAPE_SINE:    w_q <= SINE_TBL[idx_q];
        SHAPE_TRI:     w_q <= tri_q;
        SHAPE_MOD:     w_q <= MOD_TBL[idx_q];
        SHAPE_MOD_ALT: w_q <= MOD_TBL[idx_q];
        default:       w_q <= MOD_TBL[idx_q];
      endcase
    end
  end

  assign depth_sat = (depth > DEPTH_FULL) ? DEPTH_FULL : depth;
  assign diff_wide = 18'sd32768 - 18'(w_q);

  // one multiplier: depth * (1 - w) first, then |sample| * gain
  always_comb begin
    if (cmd.gain) begin
      op_a = MUL_BITS'(depth_sat);
      op_b = MUL_BITS'(diff_wide[16:0]);
    end else begin
      op_a = MUL_BITS'(mag_q);
      op_b = g_q;
    end
  end

  assign prod = op_a * op_b;
  assign res  = prod[SAMPLE_BITS+30:31];

  always_ff @(posedge clk) begin
    if (cmd.gain) g_q <= 32'h8000_0000 - prod[MUL_BITS-1:0];
    if (cmd.scale) sample_out <= neg_q ? (~res + SAMPLE_BITS'(1)) : res;
  end

endmodule
